// ----- rtl/core/cstl_pkg.sv -----
// ----------------------------------------------------------------------------
// cstl_pkg
// Shared constants, token codes and the controller/datapath command and
// status bundles of the token lexer.
// ----------------------------------------------------------------------------
package cstl_pkg;

    // number of identifier characters that are kept
    localparam int IDENT_KEEP = 31;
    // width of the kept-length count (holds IDENT_KEEP itself)
    localparam int LEN_W = $clog2(IDENT_KEEP + 1);
    // width of an index into the identifier store
    localparam int IDX_W = $clog2(IDENT_KEEP);

    // character codes
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0a;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_BSLASH  = 8'h5c;
    localparam logic [7:0] CH_EQUALS  = 8'h3d;
    localparam logic [7:0] CH_LOWER_N = 8'h6e;

    // result kinds
    localparam logic RK_TEXT  = 1'b0;
    localparam logic RK_TOKEN = 1'b1;

    // token codes
    typedef enum logic [4:0] {
        TK_INT    = 5'd0,
        TK_ID     = 5'd1,
        TK_NUM    = 5'd2,
        TK_STRING = 5'd3,
        TK_IF     = 5'd4,
        TK_WHILE  = 5'd5,
        TK_PRINT  = 5'd6,
        TK_RETURN = 5'd7,
        TK_PLUS   = 5'd8,
        TK_MINUS  = 5'd9,
        TK_STAR   = 5'd10,
        TK_SLASH  = 5'd11,
        TK_LT     = 5'd12,
        TK_GT     = 5'd13,
        TK_EQ     = 5'd14,
        TK_ASSIGN = 5'd15,
        TK_LPAREN = 5'd16,
        TK_RPAREN = 5'd17,
        TK_LBRACE = 5'd18,
        TK_RBRACE = 5'd19,
        TK_SEMI   = 5'd20,
        TK_END    = 5'd21
    } tok_e_t;

    // which part of the byte's work feeds the result register
    typedef enum logic [1:0] {
        SRC_RUN   = 2'd0,   // one kept identifier character
        SRC_FLUSH = 2'd1,   // token or character that closes the pending mode
        SRC_STR   = 2'd2,   // string character or string token
        SRC_IDLE  = 2'd3    // end token or operator token
    } src_e_t;

    // commands from controller to datapath
    typedef struct packed {
        logic   accept;     // latch the byte, clear the run index
        logic   load;       // load the result register
        src_e_t src;
        logic   last;       // final result of this byte
        logic   idx_inc;    // step the identifier run index
        logic   commit;     // apply the byte's state update
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic flush_has;    // pending mode emits on this byte
        logic flush_run;    // that emission starts with an identifier text run
        logic run_done;     // every kept character has gone out
        logic str_has;      // string handling emits
        logic idle_has;     // idle handling emits
        logic out_free;     // result register can take a value this cycle
    } sts_t;

endpackage

// ----- rtl/core/cstl_ctrl.sv -----
// ----------------------------------------------------------------------------
// cstl_ctrl
// Sequencer of the token lexer: takes a byte, then walks the flush, string
// and idle phases, issuing at most one result per cycle into the result register while it is free.
// ----------------------------------------------------------------------------
module cstl_ctrl
    import cstl_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_WAIT,
        ST_FLUSH,
        ST_STR,
        ST_IDLE
    } state_t;

    state_t state_reg, state_next;

    // phase sequencing
    always_comb begin
        state_next  = state_reg;
        s_ready     = 1'b0;
        cmd         = '0;
        cmd.src     = SRC_RUN;
        unique case (state_reg)
            ST_WAIT: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!sts.flush_has) begin
                    state_next = ST_STR;
                end else if (sts.flush_run && !sts.run_done) begin
                    // identifier text, one character a cycle while the result register is free
                    if (sts.out_free) begin
                        cmd.load    = 1'b1;
                        cmd.src     = SRC_RUN;
                        cmd.idx_inc = 1'b1;
                    end
                end else if (sts.out_free) begin
                    cmd.load   = 1'b1;
                    cmd.src    = SRC_FLUSH;
                    cmd.last   = !sts.str_has && !sts.idle_has;
                    state_next = ST_STR;
                end
            end
            ST_STR: begin
                if (!sts.str_has) begin
                    state_next = ST_IDLE;
                end else if (sts.out_free) begin
                    cmd.load   = 1'b1;
                    cmd.src    = SRC_STR;
                    cmd.last   = !sts.idle_has;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (!sts.idle_has) begin
                    cmd.commit = 1'b1;
                    state_next = ST_WAIT;
                end else if (sts.out_free) begin
                    cmd.load   = 1'b1;
                    cmd.src    = SRC_IDLE;
                    cmd.last   = 1'b1;
                    cmd.commit = 1'b1;
                    state_next = ST_WAIT;
                end
            end
            default: begin
                state_next = ST_WAIT;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_WAIT;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/core/cstl_dpath.sv -----
// ----------------------------------------------------------------------------
// cstl_dpath
// Datapath of the token lexer: scan mode, number accumulator, identifier
// store, byte classification, keyword match and the result register.
// ----------------------------------------------------------------------------
module cstl_dpath
    import cstl_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [7:0]         s_text_byte,
    input  logic               m_ready,
    output logic               m_valid,
    output logic               m_result_kind,
    output logic [4:0]         m_token_kind,
    output logic signed [31:0] m_number_value,
    output logic [7:0]         m_text_char,
    output logic               m_last_of_run,
    input  cmd_t               cmd,
    output sts_t               sts
);

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_NUM,
        MODE_IDENT,
        MODE_STR,
        MODE_STR_BS,
        MODE_EQ
    } mode_t;

    localparam int KW_N   = 5;
    localparam int KW_MAX = 6;

    localparam logic [7:0] KW_TEXT [KW_N][KW_MAX] = '{
        '{"i", "n", "t", 8'h00, 8'h00, 8'h00},
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"w", "h", "i", "l", "e", 8'h00},
        '{"p", "r", "i", "n", "t", 8'h00},
        '{"r", "e", "t", "u", "r", "n"}
    };
    localparam logic [2:0] KW_LEN [KW_N] = '{3'd3, 3'd2, 3'd5, 3'd5, 3'd6};
    localparam tok_e_t KW_TOK [KW_N] = '{TK_INT, TK_IF, TK_WHILE, TK_PRINT, TK_RETURN};

    mode_t              mode_reg, mode_next;
    logic [31:0]        acc_reg, acc_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [LEN_W-1:0]   idx_reg, idx_next;
    logic [7:0]         byte_reg;
    logic [7:0]         store_reg [IDENT_KEEP];

    logic               m_valid_reg, m_valid_next;
    logic               kind_reg;
    tok_e_t             tok_reg;
    logic [31:0]        val_reg;
    logic [7:0]         char_reg;
    logic               last_reg;

    logic               is_digit, is_alpha, is_alnum, is_skip;
    logic               use_str, use_idle;
    logic               kw_hit;
    tok_e_t             kw_tok;
    logic               op_hit;
    tok_e_t             op_tok;
    logic [3:0]         digit;
    logic               store_we;
    logic [IDX_W-1:0]   store_addr;

    logic               res_kind;
    tok_e_t             res_tok;
    logic [31:0]        res_val;
    logic [7:0]         res_char;

    // byte classification
    assign is_digit = (byte_reg >= "0") && (byte_reg <= "9");
    assign is_alpha = ((byte_reg >= "a") && (byte_reg <= "z"))
                   || ((byte_reg >= "A") && (byte_reg <= "Z"))
                   || (byte_reg == "_");
    assign is_alnum = is_digit || is_alpha;
    assign is_skip  = (byte_reg <= CH_SPACE) || byte_reg[7];
    assign digit    = 4'(byte_reg - "0");

    // operator lookup
    always_comb begin
        op_hit = 1'b1;
        op_tok = TK_END;
        unique case (byte_reg)
            "+":     op_tok = TK_PLUS;
            "-":     op_tok = TK_MINUS;
            "*":     op_tok = TK_STAR;
            "/":     op_tok = TK_SLASH;
            "<":     op_tok = TK_LT;
            ">":     op_tok = TK_GT;
            "(":     op_tok = TK_LPAREN;
            ")":     op_tok = TK_RPAREN;
            "{":     op_tok = TK_LBRACE;
            "}":     op_tok = TK_RBRACE;
            ";":     op_tok = TK_SEMI;
            default: op_hit = 1'b0;
        endcase
    end

    // keyword match on the kept identifier
    always_comb begin
        logic same;
        kw_hit = 1'b0;
        kw_tok = TK_ID;
        for (int k = 0; k < KW_N; k++) begin
            same = (len_reg == LEN_W'(KW_LEN[k]));
            for (int i = 0; i < KW_MAX; i++) begin
                if ((i < int'(KW_LEN[k])) && (store_reg[i] != KW_TEXT[k][i])) begin
                    same = 1'b0;
                end
            end
            if (same && !kw_hit) begin
                kw_hit = 1'b1;
                kw_tok = KW_TOK[k];
            end
        end
    end

    // which phases handle this byte
    assign use_str  = (mode_reg == MODE_STR)
                   || ((mode_reg == MODE_STR_BS) && (byte_reg != CH_LOWER_N));
    assign use_idle = (mode_reg == MODE_IDLE)
                   || ((mode_reg == MODE_NUM) && !is_digit)
                   || ((mode_reg == MODE_IDENT) && !is_alnum)
                   || ((mode_reg == MODE_EQ) && (byte_reg != CH_EQUALS))
                   || (use_str && (byte_reg == CH_NUL));

    // status to the controller
    always_comb begin
        sts.flush_has = ((mode_reg == MODE_NUM) && !is_digit)
                     || ((mode_reg == MODE_IDENT) && !is_alnum)
                     || (mode_reg == MODE_STR_BS)
                     || (mode_reg == MODE_EQ);
        sts.flush_run = (mode_reg == MODE_IDENT) && !kw_hit;
        sts.run_done  = (idx_reg == len_reg);
        sts.str_has   = use_str && (byte_reg != CH_BSLASH);
        sts.idle_has  = use_idle && ((byte_reg == CH_NUL) || op_hit);
        sts.out_free  = !m_valid_reg || m_ready;
    end

    // result selection
    always_comb begin
        res_kind = RK_TOKEN;
        res_tok  = TK_END;
        res_val  = '0;
        res_char = CH_NUL;
        unique case (cmd.src)
            SRC_RUN: begin
                res_kind = RK_TEXT;
                res_tok  = TK_ID;
                res_char = store_reg[idx_reg[IDX_W-1:0]];
            end
            SRC_FLUSH: begin
                priority case (mode_reg)
                    MODE_NUM: begin
                        res_tok = TK_NUM;
                        res_val = acc_reg;
                    end
                    MODE_IDENT: begin
                        res_tok = kw_hit ? kw_tok : TK_ID;
                    end
                    MODE_STR_BS: begin
                        res_kind = RK_TEXT;
                        res_tok  = TK_STRING;
                        res_char = (byte_reg == CH_LOWER_N) ? CH_NEWLINE : CH_BSLASH;
                    end
                    default: begin
                        res_tok = (byte_reg == CH_EQUALS) ? TK_EQ : TK_ASSIGN;
                    end
                endcase
            end
            SRC_STR: begin
                res_tok = TK_STRING;
                if ((byte_reg != CH_NUL) && (byte_reg != CH_QUOTE)) begin
                    res_kind = RK_TEXT;
                    res_char = byte_reg;
                end
            end
            SRC_IDLE: begin
                res_tok = (byte_reg == CH_NUL) ? TK_END : op_tok;
            end
            default: begin
                res_tok = TK_END;
            end
        endcase
    end

    // state update at the end of the byte's work
    always_comb begin
        mode_next  = mode_reg;
        acc_next   = acc_reg;
        len_next   = len_reg;
        store_we   = 1'b0;
        store_addr = len_reg[IDX_W-1:0];
        if (use_idle) begin
            len_next = '0;
            if (byte_reg == CH_NUL) begin
                mode_next = MODE_IDLE;
                acc_next  = '0;
            end else if (is_skip) begin
                mode_next = MODE_IDLE;
            end else if (is_digit) begin
                mode_next = MODE_NUM;
                acc_next  = 32'(digit);
            end else if (is_alpha) begin
                mode_next  = MODE_IDENT;
                store_we   = 1'b1;
                store_addr = '0;
                len_next   = LEN_W'(1);
            end else if (byte_reg == CH_QUOTE) begin
                mode_next = MODE_STR;
            end else if (byte_reg == CH_EQUALS) begin
                mode_next = MODE_EQ;
            end else begin
                mode_next = MODE_IDLE;
            end
        end else if (use_str) begin
            if (byte_reg == CH_QUOTE) begin
                mode_next = MODE_IDLE;
            end else if (byte_reg == CH_BSLASH) begin
                mode_next = MODE_STR_BS;
            end else begin
                mode_next = MODE_STR;
            end
        end else if (mode_reg == MODE_NUM) begin
            // acc * 10 + digit, wrapping
            acc_next = {acc_reg[28:0], 3'b000} + {acc_reg[30:0], 1'b0} + 32'(digit);
        end else if (mode_reg == MODE_IDENT) begin
            if (len_reg < LEN_W'(IDENT_KEEP)) begin
                store_we = 1'b1;
                len_next = len_reg + LEN_W'(1);
            end
        end else if (mode_reg == MODE_STR_BS) begin
            mode_next = MODE_STR;
        end else begin
            mode_next = MODE_IDLE;
        end
    end

    // run index
    always_comb begin
        idx_next = idx_reg;
        if (cmd.accept) begin
            idx_next = '0;
        end else if (cmd.idx_inc) begin
            idx_next = idx_reg + LEN_W'(1);
        end
    end

    // result register handshake
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_IDLE;
            acc_reg     <= '0;
            len_reg     <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.commit) begin
                mode_reg <= mode_next;
                acc_reg  <= acc_next;
                len_reg  <= len_next;
            end
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            byte_reg <= s_text_byte;
        end
        if (cmd.commit && store_we) begin
            store_reg[store_addr] <= byte_reg;
        end
        if (cmd.load) begin
            kind_reg <= res_kind;
            tok_reg  <= res_tok;
            val_reg  <= res_val;
            char_reg <= res_char;
            last_reg <= cmd.last;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result_kind  = kind_reg;
    assign m_token_kind   = tok_reg;
    assign m_number_value = val_reg;
    assign m_text_char    = char_reg;
    assign m_last_of_run  = last_reg;

endmodule

// ----- rtl/core/c_subset_token_lexer.sv -----
// ----------------------------------------------------------------------------
// c_subset_token_lexer
// Streaming lexer for a small C-like language, one source byte per
// transaction in, one text character or finished token per transaction out.
// ----------------------------------------------------------------------------
// Each accepted byte is taken in the wait state and then passes through the
// flush, string and idle phases, each of which, apart from the identifier
// text, places at most one result in the single output register. A byte that
// ends a non-keyword identifier first sends every kept character (up to 31)
// in the flush phase, one character per cycle while the output register is
// free, ahead of the identifier token. A phase waits while the output register
// is full and not taken. The next byte is accepted while the last result of
// the previous one still waits in the output register. The number of results
// per byte ranges from none to 33; m_last_of_run marks the last one.
module c_subset_token_lexer
    import cstl_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_text_byte,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_result_kind,
    output logic [4:0]         m_token_kind,
    output logic signed [31:0] m_number_value,
    output logic [7:0]         m_text_char,
    output logic               m_last_of_run
);

    cmd_t cmd;
    sts_t sts;

    // phase controller
    cstl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // lexer datapath and result register
    cstl_dpath u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_text_byte    (s_text_byte),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_result_kind  (m_result_kind),
        .m_token_kind   (m_token_kind),
        .m_number_value (m_number_value),
        .m_text_char    (m_text_char),
        .m_last_of_run  (m_last_of_run),
        .cmd            (cmd),
        .sts            (sts)
    );

endmodule
